// ----- sv/ilps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilps_pkg
// shared types, codes and constants of the inactivity low-power sequencer
// ----------------------------------------------------------------------------
package ilps_pkg;

    localparam int TIMER_BITS = 16;
    localparam int DIV_W      = 16;
    localparam int HOLD_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [HOLD_W-1:0] HOLD_RESET      = HOLD_W'(1000);
    localparam logic [DIV_W-1:0]  LOW_DIV_RESET   = DIV_W'(1);

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_VOICE = 2'd1,
        CMD_SAFE  = 2'd2,
        CMD_QUERY = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_FULL     = 2'd0,
        MODE_GOING_LOW = 2'd1,
        MODE_LOW      = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        MSG_REQ_LOW = 2'd0,
        MSG_CANCEL  = 2'd1,
        MSG_WAKE    = 2'd2
    } t_msg;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOLD_TICKS = 2'd0,
        CFG_LOW_PROC   = 2'd1,
        CFG_LOW_SWITCH = 2'd2,
        CFG_SW_ENABLE  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [HOLD_W-1:0] hold_ticks;
        logic [DIV_W-1:0]  low_proc_divider;
        logic [DIV_W-1:0]  low_switch_divider;
        logic              switch_scaling_enable;
    } t_cfg;

    typedef struct packed {
        logic [1:0]       power_mode;
        logic             message_valid;
        logic [1:0]       message_code;
        logic             proc_divider_write;
        logic [DIV_W-1:0] proc_divider_value;
        logic             switch_divider_write;
        logic [DIV_W-1:0] switch_divider_value;
    } t_result;

    function automatic logic [TIMER_BITS-1:0] hold_to_timer(input logic [HOLD_W-1:0] hold);
        logic [HOLD_W+TIMER_BITS-1:0] ext;
        ext = {{TIMER_BITS{1'b0}}, hold};
        return ext[TIMER_BITS-1:0];
    endfunction

endpackage

// ----- sv/ilps_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilps_cfg_regs
// configuration register file, one write per transfer
// ----------------------------------------------------------------------------
module ilps_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_we,
    input  logic [ilps_pkg::CFG_IDX_W-1:0]  i_index,
    input  logic [ilps_pkg::CFG_DATA_W-1:0] i_data,
    output ilps_pkg::t_cfg                o_cfg
);

    ilps_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_ticks            <= ilps_pkg::HOLD_RESET;
            r_cfg.low_proc_divider      <= ilps_pkg::LOW_DIV_RESET;
            r_cfg.low_switch_divider    <= ilps_pkg::LOW_DIV_RESET;
            r_cfg.switch_scaling_enable <= 1'b0;
        end else if (i_we) begin
            unique case (ilps_pkg::t_cfg_idx'(i_index))
                ilps_pkg::CFG_HOLD_TICKS: begin
                    r_cfg.hold_ticks <= i_data[ilps_pkg::HOLD_W-1:0];
                end
                ilps_pkg::CFG_LOW_PROC: begin
                    r_cfg.low_proc_divider <= i_data[ilps_pkg::DIV_W-1:0];
                end
                ilps_pkg::CFG_LOW_SWITCH: begin
                    r_cfg.low_switch_divider <= i_data[ilps_pkg::DIV_W-1:0];
                end
                ilps_pkg::CFG_SW_ENABLE: begin
                    r_cfg.switch_scaling_enable <= i_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- sv/ilps_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilps_core
// power mode state machine, hold timer and saved dividers
// ----------------------------------------------------------------------------
module ilps_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic [1:0]                i_command,
    input  logic [ilps_pkg::DIV_W-1:0] i_present_proc_divider,
    input  logic [ilps_pkg::DIV_W-1:0] i_present_switch_divider,
    input  ilps_pkg::t_cfg            i_cfg,
    output ilps_pkg::t_result         o_result
);

    ilps_pkg::t_mode                   r_mode, n_mode;
    logic                              r_armed, n_armed;
    logic [ilps_pkg::TIMER_BITS-1:0]   r_ticks, n_ticks;
    logic [ilps_pkg::DIV_W-1:0]        r_saved_proc, n_saved_proc;
    logic [ilps_pkg::DIV_W-1:0]        r_saved_sw, n_saved_sw;
    ilps_pkg::t_result                 res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= ilps_pkg::MODE_FULL;
            r_armed      <= 1'b1;
            r_ticks      <= ilps_pkg::hold_to_timer(ilps_pkg::HOLD_RESET);
            r_saved_proc <= '0;
            r_saved_sw   <= '0;
        end else if (i_push) begin
            r_mode       <= n_mode;
            r_armed      <= n_armed;
            r_ticks      <= n_ticks;
            r_saved_proc <= n_saved_proc;
            r_saved_sw   <= n_saved_sw;
        end
    end

    always_comb begin
        n_mode       = r_mode;
        n_armed      = r_armed;
        n_ticks      = r_ticks;
        n_saved_proc = r_saved_proc;
        n_saved_sw   = r_saved_sw;
        res          = '0;
        case (ilps_pkg::t_cmd'(i_command))
            ilps_pkg::CMD_TICK: begin
                if (r_armed) begin
                    if (r_ticks <= ilps_pkg::TIMER_BITS'(1)) begin
                        n_ticks           = '0;
                        n_armed           = 1'b0;
                        n_mode            = ilps_pkg::MODE_GOING_LOW;
                        res.message_valid = 1'b1;
                        res.message_code  = ilps_pkg::MSG_REQ_LOW;
                    end else begin
                        n_ticks = r_ticks - ilps_pkg::TIMER_BITS'(1);
                    end
                end
            end
            ilps_pkg::CMD_VOICE: begin
                unique case (r_mode)
                    ilps_pkg::MODE_GOING_LOW: begin
                        res.message_valid = 1'b1;
                        res.message_code  = ilps_pkg::MSG_CANCEL;
                    end
                    ilps_pkg::MODE_LOW: begin
                        if (i_cfg.switch_scaling_enable) begin
                            res.switch_divider_write = 1'b1;
                            res.switch_divider_value = r_saved_sw;
                        end
                        res.proc_divider_write = 1'b1;
                        res.proc_divider_value = r_saved_proc;
                        res.message_valid      = 1'b1;
                        res.message_code       = ilps_pkg::MSG_WAKE;
                    end
                    default: begin
                    end
                endcase
                n_mode  = ilps_pkg::MODE_FULL;
                n_armed = 1'b1;
                n_ticks = ilps_pkg::hold_to_timer(i_cfg.hold_ticks);
            end
            ilps_pkg::CMD_SAFE: begin
                if (r_mode == ilps_pkg::MODE_GOING_LOW) begin
                    n_armed                = 1'b0;
                    n_mode                 = ilps_pkg::MODE_LOW;
                    n_saved_proc           = i_present_proc_divider;
                    res.proc_divider_write = 1'b1;
                    res.proc_divider_value = i_cfg.low_proc_divider;
                    if (i_cfg.switch_scaling_enable) begin
                        n_saved_sw               = i_present_switch_divider;
                        res.switch_divider_write = 1'b1;
                        res.switch_divider_value = i_cfg.low_switch_divider;
                    end
                end
            end
            default: begin
            end
        endcase
        res.power_mode = n_mode;
    end

    assign o_result = res;

endmodule

// ----- sv/ilps_out_buf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilps_out_buf
// result register with skid entry, decouples the two channels
// ----------------------------------------------------------------------------
module ilps_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ilps_pkg::t_result i_result,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_stall,
    output ilps_pkg::t_result o_result
);

    logic              r_main_valid;
    logic              r_skid_valid;
    ilps_pkg::t_result r_main;
    ilps_pkg::t_result r_skid;
    logic              pop;

    assign pop = r_main_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (i_push) begin
            if (!r_main_valid) begin
                r_main_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skid_valid) begin
                r_main <= r_skid;
            end else begin
                r_main <= i_result;
            end
        end else if (i_push) begin
            if (!r_main_valid) begin
                r_main <= i_result;
            end else begin
                r_skid <= i_result;
            end
        end
    end

    assign o_full   = r_skid_valid;
    assign o_valid  = r_main_valid;
    assign o_result = r_main;

endmodule

// ----- sv/inactivity_low_power_sequencer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inactivity_low_power_sequencer_unit
// inactivity timeout power sequencer: hold timer, power modes, divider control
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  command   i_valid / o_stall         i_command, i_present_*_divider
//  result    o_valid / i_stall         o_power_mode, o_message_*, o_*_divider_*
//  config    i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  one item per cycle while o_stall is low; the result is registered on transfer
//  the state update and the result come from one pass of logic in the core
//  o_stall rises only when both the result register and the skid entry hold
//  results; config writes are always taken
//  synchronous active-low reset restores register defaults and an armed timer
// ----------------------------------------------------------------------------
module inactivity_low_power_sequencer_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [1:0]                     i_command,
    input  logic [ilps_pkg::DIV_W-1:0]     i_present_proc_divider,
    input  logic [ilps_pkg::DIV_W-1:0]     i_present_switch_divider,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [1:0]                     o_power_mode,
    output logic                           o_message_valid,
    output logic [1:0]                     o_message_code,
    output logic                           o_proc_divider_write,
    output logic [ilps_pkg::DIV_W-1:0]     o_proc_divider_value,
    output logic                           o_switch_divider_write,
    output logic [ilps_pkg::DIV_W-1:0]     o_switch_divider_value,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ilps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ilps_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    ilps_pkg::t_cfg    cfg;
    ilps_pkg::t_result core_res;
    ilps_pkg::t_result out_res;
    logic              push;
    logic              full;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = full;
    assign push        = i_valid && !full;

    ilps_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    ilps_core u_core (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_push                   (push),
        .i_command                (i_command),
        .i_present_proc_divider   (i_present_proc_divider),
        .i_present_switch_divider (i_present_switch_divider),
        .i_cfg                    (cfg),
        .o_result                 (core_res)
    );

    ilps_out_buf u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (core_res),
        .o_full   (full),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (out_res)
    );

    assign o_power_mode           = out_res.power_mode;
    assign o_message_valid        = out_res.message_valid;
    assign o_message_code         = out_res.message_code;
    assign o_proc_divider_write   = out_res.proc_divider_write;
    assign o_proc_divider_value   = out_res.proc_divider_value;
    assign o_switch_divider_write = out_res.switch_divider_write;
    assign o_switch_divider_value = out_res.switch_divider_value;

    // a transfer in always leaves a result waiting
    a_push_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> o_valid)
        else $error("no result after input transfer");

    // skid entry is only used behind a held result
    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("skid entry full with empty result register");

    // idle message and divider fields read as zero
    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_message_valid || (o_message_code == 2'd0)) &&
                     (o_proc_divider_write || (o_proc_divider_value == '0)) &&
                     (o_switch_divider_write || (o_switch_divider_value == '0))))
        else $error("idle result field not zero");

    // an unused mode code never shows up
    a_mode_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_power_mode != 2'd3))
        else $error("power mode out of range");

endmodule
